>>> hw/rtl/ntpc_pkg.sv
package ntpc_pkg;

    // Field widths of the channels.
    localparam int unsigned NORMAL_W   = 16;
    localparam int unsigned COV_W      = 32;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 31;

    // Configuration registers.
    localparam int unsigned RATIO_W = 31;
    localparam int unsigned EPS_W   = 21;

    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_RATIO = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DIAG_EPSILON = CFG_IDX_W'(1);

    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(24159191);
    localparam logic [EPS_W-1:0]   EPS_RESET   = EPS_W'(11);
    localparam logic [RATIO_W-1:0] ALPHA_FLOOR = RATIO_W'(1073742);
    localparam logic [RATIO_W-1:0] ONE_Q30     = RATIO_W'(1073741824);

    // Datapath widths.
    localparam int unsigned NUM_TERMS = 6;
    localparam int unsigned PROD_W    = 2 * NORMAL_W;
    localparam int unsigned PMAG_W    = PROD_W - 1;
    localparam int unsigned SUM_W     = PROD_W;
    localparam int unsigned DMAG_W    = RATIO_W - 1;
    localparam int unsigned MAG_W     = DMAG_W + PMAG_W;
    localparam int unsigned NUM_W     = MAG_W + 1;
    localparam int unsigned DEN_W     = SUM_W + 1;
    localparam int unsigned QUO_W     = 31;
    localparam int unsigned ACC_W     = COV_W + 1;

    // Term order: xx, xy, xz, yy, yz, zz.
    localparam int unsigned TERM_XX = 0;
    localparam int unsigned TERM_XY = 1;
    localparam int unsigned TERM_XZ = 2;
    localparam int unsigned TERM_YY = 3;
    localparam int unsigned TERM_YZ = 4;
    localparam int unsigned TERM_ZZ = 5;

    localparam logic [1:0] TERM_A [NUM_TERMS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] TERM_B [NUM_TERMS] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};
    localparam logic [NUM_TERMS-1:0] TERM_DIAG = 6'b101001;

    typedef struct packed {
        logic                 valid;
        logic [NUM_TERMS-1:0] neg;
    } div_tag_t;

endpackage

>>> hw/rtl/ntpc_in_if.sv
interface ntpc_in_if import ntpc_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [NORMAL_W-1:0] nrm_x;
    logic signed [NORMAL_W-1:0] nrm_y;
    logic signed [NORMAL_W-1:0] nrm_z;
    logic                       normal_finite;

    modport source (
        output valid, nrm_x, nrm_y, nrm_z, normal_finite,
        input  ready
    );

    modport sink (
        input  valid, nrm_x, nrm_y, nrm_z, normal_finite,
        output ready
    );

endinterface

>>> hw/rtl/ntpc_out_if.sv
interface ntpc_out_if import ntpc_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic signed [COV_W-1:0] cov_xx;
    logic signed [COV_W-1:0] cov_xy;
    logic signed [COV_W-1:0] cov_xz;
    logic signed [COV_W-1:0] cov_yy;
    logic signed [COV_W-1:0] cov_yz;
    logic signed [COV_W-1:0] cov_zz;

    modport source (
        output valid, cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz,
        input  ready
    );

    modport sink (
        input  valid, cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz,
        output ready
    );

endinterface

>>> hw/rtl/ntpc_cfg_if.sv
interface ntpc_cfg_if import ntpc_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );

endinterface

>>> hw/rtl/ntpc_div_pipe.sv
module ntpc_div_pipe import ntpc_pkg::*; (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  div_tag_t                            tag_in,
    input  logic [NUM_TERMS-1:0][NUM_W-1:0]     num_in,
    input  logic [DEN_W-1:0]                    den_in,
    output div_tag_t                            tag_out,
    output logic [NUM_TERMS-1:0][QUO_W-1:0]     quo_out
);

    // One restoring step: the remainder takes the next dividend bit and the
    // quotient bit enters at the bottom of the shifting dividend word.
    function automatic logic [DEN_W+QUO_W-1:0] div_step(
        input logic [DEN_W-1:0] rem,
        input logic [QUO_W-1:0] low,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;
        trial = {rem, low[QUO_W-1]};
        diff  = trial - {1'b0, den};
        ge    = (trial >= {1'b0, den});
        if (ge)
        begin
            return {diff[DEN_W-1:0], low[QUO_W-2:0], 1'b1};
        end
        return {trial[DEN_W-1:0], low[QUO_W-2:0], 1'b0};
    endfunction

    localparam int unsigned HI_W = NUM_W - QUO_W;

    div_tag_t                          tag_reg  [QUO_W];
    logic [DEN_W-1:0]                  den_reg  [QUO_W];
    logic [NUM_TERMS-1:0][DEN_W-1:0]   rem_reg  [QUO_W];
    logic [NUM_TERMS-1:0][QUO_W-1:0]   low_reg  [QUO_W];
    logic [NUM_TERMS-1:0][DEN_W-1:0]   rem_next [QUO_W];
    logic [NUM_TERMS-1:0][QUO_W-1:0]   low_next [QUO_W];

    genvar g, k;
    generate
        for (g = 0; g < QUO_W; g++)
        begin : g_stage
            div_tag_t                        tag_src;
            logic [DEN_W-1:0]                den_src;
            logic [NUM_TERMS-1:0][DEN_W-1:0] rem_src;
            logic [NUM_TERMS-1:0][QUO_W-1:0] low_src;

            if (g == 0)
            begin : g_first
                assign tag_src = tag_in;
                assign den_src = den_in;
                for (k = 0; k < NUM_TERMS; k++)
                begin : g_lane_in
                    // The quotient is known to fit QUO_W bits, so the top part
                    // of the dividend is already below the divisor.
                    assign rem_src[k] = {{(DEN_W-HI_W){1'b0}}, num_in[k][NUM_W-1:QUO_W]};
                    assign low_src[k] = num_in[k][QUO_W-1:0];
                end
            end
            else
            begin : g_rest
                assign tag_src = tag_reg[g-1];
                assign den_src = den_reg[g-1];
                assign rem_src = rem_reg[g-1];
                assign low_src = low_reg[g-1];
            end

            for (k = 0; k < NUM_TERMS; k++)
            begin : g_lane
                assign {rem_next[g][k], low_next[g][k]} = div_step(rem_src[k], low_src[k], den_src);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    tag_reg[g] <= '0;
                end
                else if (en)
                begin
                    tag_reg[g] <= tag_src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[g] <= den_src;
                    rem_reg[g] <= rem_next[g];
                    low_reg[g] <= low_next[g];
                end
            end
        end
    endgenerate

    assign tag_out = tag_reg[QUO_W-1];
    assign quo_out = low_reg[QUO_W-1];

endmodule

>>> hw/rtl/normal_to_plane_covariance_unit.sv
// Plane-shaped covariance from a surface normal.
// The normal channel takes one item per cycle: three signed Q2.14 normal
// components and a finite flag. The cov channel gives one item per input:
// the six distinct entries of (1 + eps) I + (alpha - 1) n n^T in signed
// Q2.30, rounded to nearest with ties away from zero and saturated.
// A non-finite or all-zero normal is treated as (0,0,1).
// The cfg channel writes normal_ratio (index 0) and diag_epsilon (index 1);
// other indexes are ignored. It is always ready; the user must write it only
// while no item is in flight, since the block itself does not enforce this.
// From acceptance to cov.valid an item passes the registers of input select,
// products, magnitudes, scaling multiply and rounding offset, then a
// one-bit-per-stage restoring divider for each of the six terms, and the
// output register. Throughput is one item per cycle.
// When the receiver stalls, the output register holds its item while the
// pipeline keeps moving until an item reaches the last divider stage; then
// every stage freezes and normal.ready drops until the output is taken.
// Reset empties the pipeline and loads the register defaults (0.0225 and
// about 1e-8).
module normal_to_plane_covariance_unit import ntpc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    ntpc_in_if.sink           normal,
    ntpc_out_if.source        cov,
    ntpc_cfg_if.sink          cfg
);

    // Configuration and values derived from it.
    logic [RATIO_W-1:0]  ratio_reg;
    logic [EPS_W-1:0]    eps_reg;
    logic [RATIO_W-1:0]  alpha_next;
    logic [RATIO_W-1:0]  dmag_next;
    logic [DMAG_W-1:0]   dmag_reg;
    logic                dneg_reg;
    logic [RATIO_W-1:0]  diag0_reg;

    // Pipeline control.
    logic adv;
    logic out_upd;

    // Stage 1: selected normal.
    logic                              s1_vld_reg;
    logic signed [NORMAL_W-1:0]        s1_v_reg    [3];
    logic signed [NORMAL_W-1:0]        s1_v_next   [3];
    logic                              force_z;

    // Stage 2: component products.
    logic                              s2_vld_reg;
    logic signed [PROD_W-1:0]          s2_prod_reg [NUM_TERMS];

    // Stage 3: squared length, magnitudes and signs.
    logic                              s3_vld_reg;
    logic [SUM_W-1:0]                  s3_sum_reg;
    logic [PMAG_W-1:0]                 s3_pmag_reg [NUM_TERMS];
    logic [NUM_TERMS-1:0]              s3_neg_reg;
    logic [SUM_W-1:0]                  s3_sum_next;
    logic [PROD_W-1:0]                 s3_pabs     [NUM_TERMS];

    // Stage 4: scaled magnitudes.
    logic                              s4_vld_reg;
    logic [SUM_W-1:0]                  s4_sum_reg;
    logic [MAG_W-1:0]                  s4_mag_reg  [NUM_TERMS];
    logic [NUM_TERMS-1:0]              s4_neg_reg;

    // Stage 5: dividend and divisor for rounded division.
    div_tag_t                          s5_tag_reg;
    logic [NUM_TERMS-1:0][NUM_W-1:0]   s5_num_reg;
    logic [DEN_W-1:0]                  s5_den_reg;

    // Divider output and result register.
    div_tag_t                          div_tag;
    logic [NUM_TERMS-1:0][QUO_W-1:0]   div_quo;
    logic                              out_vld_reg;
    logic signed [COV_W-1:0]           cov_reg     [NUM_TERMS];
    logic signed [COV_W-1:0]           cov_next    [NUM_TERMS];

    // ------------------------------------------------------------------
    // Configuration.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= RATIO_RESET;
            eps_reg   <= EPS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_NORMAL_RATIO: ratio_reg <= cfg.data[RATIO_W-1:0];
                REG_DIAG_EPSILON: eps_reg   <= cfg.data[EPS_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        alpha_next = (ratio_reg < ALPHA_FLOOR) ? ALPHA_FLOOR : ratio_reg;
        dmag_next  = (alpha_next < ONE_Q30) ? (ONE_Q30 - alpha_next) : (alpha_next - ONE_Q30);
    end

    // Registered once more so the multiplier sees a plain register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dmag_reg  <= '0;
            dneg_reg  <= 1'b0;
            diag0_reg <= '0;
        end
        else
        begin
            dmag_reg  <= dmag_next[DMAG_W-1:0];
            dneg_reg  <= (alpha_next < ONE_Q30);
            diag0_reg <= ONE_Q30 + RATIO_W'(eps_reg);
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the output register is refilled when empty or taken;
    // the pipeline may also move while its last stage holds a bubble.
    assign out_upd      = cov.ready || !out_vld_reg;
    assign adv          = out_upd || !div_tag.valid;
    assign normal.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_tag_reg <= '0;
        end
        else if (adv)
        begin
            s1_vld_reg       <= normal.valid;
            s2_vld_reg       <= s1_vld_reg;
            s3_vld_reg       <= s2_vld_reg;
            s4_vld_reg       <= s3_vld_reg;
            s5_tag_reg.valid <= s4_vld_reg;
            s5_tag_reg.neg   <= s4_neg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: an unusable normal becomes (0,0,1) with squared length one.
    always_comb
    begin
        force_z = !normal.normal_finite ||
                  (normal.nrm_x == '0 && normal.nrm_y == '0 && normal.nrm_z == '0);
        s1_v_next[0] = force_z ? NORMAL_W'(0) : normal.nrm_x;
        s1_v_next[1] = force_z ? NORMAL_W'(0) : normal.nrm_y;
        s1_v_next[2] = force_z ? NORMAL_W'(1) : normal.nrm_z;
    end

    // Stage 3 combinational part.
    always_comb
    begin
        s3_sum_next = SUM_W'(s2_prod_reg[TERM_XX]) + SUM_W'(s2_prod_reg[TERM_YY]) +
                      SUM_W'(s2_prod_reg[TERM_ZZ]);
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            s3_pabs[k] = s2_prod_reg[k][PROD_W-1] ? PROD_W'(-s2_prod_reg[k])
                                                  : PROD_W'(s2_prod_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_v_reg[i] <= s1_v_next[i];
            end
            for (int k = 0; k < NUM_TERMS; k++)
            begin
                s2_prod_reg[k] <= s1_v_reg[TERM_A[k]] * s1_v_reg[TERM_B[k]];
                s3_pmag_reg[k] <= s3_pabs[k][PMAG_W-1:0];
                s3_neg_reg[k]  <= s2_prod_reg[k][PROD_W-1] ^ dneg_reg;
                s4_mag_reg[k]  <= MAG_W'(dmag_reg) * MAG_W'(s3_pmag_reg[k]);
                // Rounded division: (2 * mag + s) / (2 * s).
                s5_num_reg[k]  <= {s4_mag_reg[k], 1'b0} + NUM_W'(s4_sum_reg);
            end
            s3_sum_reg <= s3_sum_next;
            s4_sum_reg <= s3_sum_reg;
            s4_neg_reg <= s3_neg_reg;
            s5_den_reg <= {s4_sum_reg, 1'b0};
        end
    end

    // ------------------------------------------------------------------
    ntpc_div_pipe u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .tag_in  (s5_tag_reg),
        .num_in  (s5_num_reg),
        .den_in  (s5_den_reg),
        .tag_out (div_tag),
        .quo_out (div_quo)
    );

    // ------------------------------------------------------------------
    // Sign, diagonal offset and saturation.
    always_comb
    begin
        logic signed [ACC_W-1:0] mag_s;
        logic signed [ACC_W-1:0] term;
        logic signed [ACC_W-1:0] total;
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            mag_s = $signed({{(ACC_W-QUO_W){1'b0}}, div_quo[k]});
            term  = div_tag.neg[k] ? -mag_s : mag_s;
            total = TERM_DIAG[k] ? term + $signed({{(ACC_W-RATIO_W){1'b0}}, diag0_reg})
                                 : term;
            if (total > $signed({{(ACC_W-COV_W+1){1'b0}}, {(COV_W-1){1'b1}}}))
            begin
                cov_next[k] = {1'b0, {(COV_W-1){1'b1}}};
            end
            else if (total < $signed({{(ACC_W-COV_W+1){1'b1}}, {(COV_W-1){1'b0}}}))
            begin
                cov_next[k] = {1'b1, {(COV_W-1){1'b0}}};
            end
            else
            begin
                cov_next[k] = total[COV_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_upd)
        begin
            out_vld_reg <= div_tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_upd)
        begin
            for (int k = 0; k < NUM_TERMS; k++)
            begin
                cov_reg[k] <= cov_next[k];
            end
        end
    end

    assign cov.valid  = out_vld_reg;
    assign cov.cov_xx = cov_reg[TERM_XX];
    assign cov.cov_xy = cov_reg[TERM_XY];
    assign cov.cov_xz = cov_reg[TERM_XZ];
    assign cov.cov_yy = cov_reg[TERM_YY];
    assign cov.cov_yz = cov_reg[TERM_YZ];
    assign cov.cov_zz = cov_reg[TERM_ZZ];

endmodule

>>> test/plane_cov_checker.sv
`timescale 1ns / 100ps

// Watches the three channels of the covariance unit and predicts each result.
// It keeps its own copy of the two registers and holds one expected covariance
// per accepted normal. Accepted results are checked in order.
module plane_cov_checker import ntpc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    ntpc_in_if   normal,
    ntpc_out_if  cov,
    ntpc_cfg_if  cfg,
    output int   fail_count,
    output int   pending,
    output int   compared
);

    typedef logic [NUM_TERMS-1:0][COV_W-1:0] cov_set_t;

    localparam longint RATIO_FLOOR_Q30 = 64'd1073742;
    localparam longint UNITY_Q30       = 64'd1073741824;
    localparam longint COV_MAX         = 64'sd2147483647;
    localparam longint COV_MIN         = -64'sd2147483648;

    // Row and column of each distinct entry, in output order xx, xy, xz, yy, yz, zz.
    localparam int ENTRY_ROW [NUM_TERMS] = '{0, 0, 0, 1, 1, 2};
    localparam int ENTRY_COL [NUM_TERMS] = '{0, 1, 2, 1, 2, 2};

    string entry_name [NUM_TERMS] = '{"cov_xx", "cov_xy", "cov_xz", "cov_yy", "cov_yz", "cov_zz"};

    logic [RATIO_W-1:0] ratio_q30;
    logic [EPS_W-1:0]   eps_q30;
    cov_set_t           cov_expected [$];
    int                 errors = 0;
    int                 checked = 0;

    function automatic cov_set_t predict_plane_cov(input logic signed [NORMAL_W-1:0] nx,
                                                   input logic signed [NORMAL_W-1:0] ny,
                                                   input logic signed [NORMAL_W-1:0] nz,
                                                   input logic finite);
        longint            comp [3];
        longint unsigned   norm_sq;
        longint            alpha;
        longint            delta;
        longint            diag_base;
        longint            prod;
        longint unsigned   mag_d;
        longint unsigned   mag_p;
        longint unsigned   quot;
        longint            entry;
        bit                negative;
        cov_set_t          res;

        comp[0] = nx;
        comp[1] = ny;
        comp[2] = nz;
        norm_sq = comp[0] * comp[0] + comp[1] * comp[1] + comp[2] * comp[2];
        if (!finite || norm_sq == 0)
        begin
            comp[0] = 0;
            comp[1] = 0;
            comp[2] = 1;
            norm_sq = 1;
        end

        alpha = longint'(ratio_q30);
        if (alpha < RATIO_FLOOR_Q30)
            alpha = RATIO_FLOOR_Q30;
        delta     = alpha - UNITY_Q30;
        diag_base = UNITY_Q30 + longint'(eps_q30);

        for (int k = 0; k < NUM_TERMS; k++)
        begin
            prod     = comp[ENTRY_ROW[k]] * comp[ENTRY_COL[k]];
            negative = (delta < 0) != (prod < 0);
            mag_d    = (delta < 0) ? -delta : delta;
            mag_p    = (prod < 0) ? -prod : prod;
            // One rounding of delta * prod / |v|^2, halves away from zero.
            quot     = (2 * mag_d * mag_p + norm_sq) / (2 * norm_sq);
            entry    = negative ? -longint'(quot) : longint'(quot);
            if (ENTRY_ROW[k] == ENTRY_COL[k])
                entry += diag_base;
            if (entry > COV_MAX)
                entry = COV_MAX;
            else if (entry < COV_MIN)
                entry = COV_MIN;
            res[k] = entry[COV_W-1:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        cov_set_t want;
        cov_set_t got;

        if (!rst_n)
        begin
            ratio_q30 = RATIO_RESET;
            eps_q30   = EPS_RESET;
            cov_expected.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_NORMAL_RATIO: ratio_q30 = cfg.data[RATIO_W-1:0];
                    REG_DIAG_EPSILON: eps_q30   = cfg.data[EPS_W-1:0];
                    default: ;
                endcase
            end

            if (normal.valid && normal.ready)
                cov_expected.push_back(predict_plane_cov(normal.nrm_x, normal.nrm_y,
                                                         normal.nrm_z, normal.normal_finite));

            if (cov.valid && cov.ready)
            begin
                got = {cov.cov_zz, cov.cov_yz, cov.cov_yy, cov.cov_xz, cov.cov_xy, cov.cov_xx};
                if (cov_expected.size() == 0)
                begin
                    errors++;
                    $display("%0t: covariance item with none expected: xx %0d", $time,
                             $signed(got[0]));
                end
                else
                begin
                    want = cov_expected.pop_front();
                    checked++;
                    for (int k = 0; k < NUM_TERMS; k++)
                    begin
                        if (got[k] !== want[k])
                        begin
                            errors++;
                            $display("%0t: %s expected %0d, got %0d", $time, entry_name[k],
                                     $signed(want[k]), $signed(got[k]));
                        end
                    end
                end
            end
        end

        pending    <= cov_expected.size();
        fail_count <= errors;
        compared   <= checked;
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import ntpc_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int PIPE_LATENCY   = 37;
    localparam int NUM_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int TIMEOUT_CYCLES = 500000;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_t;
    typedef enum int {SHAPE_ZERO, SHAPE_NONFINITE, SHAPE_AXIS, SHAPE_SMALL, SHAPE_FULL} shape_t;

    logic clk = 1'b0;
    logic rst_n;

    ntpc_in_if  normal_ch ();
    ntpc_out_if cov_ch ();
    ntpc_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int compared;
    int normals_sent;
    int burst_left;

    ready_mode_t ready_mode;
    int          mode_left;

    normal_to_plane_covariance_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .normal (normal_ch),
        .cov    (cov_ch),
        .cfg    (cfg_ch)
    );

    plane_cov_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .normal     (normal_ch),
        .cov        (cov_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .compared   (compared)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // The receiver switches at random between stall patterns.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cov_ch.ready <= 1'b0;
            ready_mode   <= READY_ALWAYS;
            mode_left    <= 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode <= ready_mode_t'($urandom_range(READY_ALWAYS, READY_PERIODIC));
                mode_left  <= $urandom_range(20, 300);
            end
            else
                mode_left <= mode_left - 1;
            case (ready_mode)
                READY_ALWAYS:   cov_ch.ready <= 1'b1;
                READY_COIN:     cov_ch.ready <= $urandom_range(0, 1);
                READY_SPARSE:   cov_ch.ready <= ($urandom_range(0, 7) == 0);
                READY_PERIODIC: cov_ch.ready <= (mode_left[2:0] < 3'd3);
                default:        cov_ch.ready <= 1'b1;
            endcase
        end
    end

    // Items go out in bursts; a gap of idle cycles may come before each burst.
    task automatic send_normal(input int x, input int y, input int z, input bit finite);
        int gap;

        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
            if (gap > 0)
            begin
                normal_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        normal_ch.valid         <= 1'b1;
        normal_ch.nrm_x         <= NORMAL_W'(x);
        normal_ch.nrm_y         <= NORMAL_W'(y);
        normal_ch.nrm_z         <= NORMAL_W'(z);
        normal_ch.normal_finite <= finite;
        @(posedge clk);
        while (!normal_ch.ready)
            @(posedge clk);
        burst_left--;
        normals_sent++;
    endtask

    task automatic send_random_normal();
        int     r;
        int     big;
        int     x;
        int     y;
        int     z;
        bit     finite;
        shape_t shape;

        r = $urandom_range(0, 15);
        shape = (r == 0) ? SHAPE_ZERO : (r == 1) ? SHAPE_NONFINITE :
                (r < 4) ? SHAPE_AXIS : (r < 6) ? SHAPE_SMALL : SHAPE_FULL;
        x = $urandom;
        y = $urandom;
        z = $urandom;
        finite = 1'b1;
        case (shape)
            SHAPE_ZERO:
            begin
                x = 0;
                y = 0;
                z = 0;
                finite = $urandom_range(0, 1);
            end
            SHAPE_NONFINITE: finite = 1'b0;
            SHAPE_AXIS:
            begin
                // A lone component drives the diagonal hardest, so saturation shows here.
                big = $urandom_range(0, 1) ? $urandom : ($urandom_range(0, 1) ? 32767 : -32768);
                x = 0;
                y = 0;
                z = 0;
                case ($urandom_range(0, 2))
                    0: x = big;
                    1: y = big;
                    default: z = big;
                endcase
            end
            SHAPE_SMALL:
            begin
                x = $urandom_range(0, 6) - 3;
                y = $urandom_range(0, 6) - 3;
                z = $urandom_range(0, 6) - 3;
            end
            default: ;
        endcase
        send_normal(x, y, z, finite);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        int ratio;
        int eps;

        rst_n                   = 1'b0;
        normal_ch.valid         = 1'b0;
        normal_ch.nrm_x         = '0;
        normal_ch.nrm_y         = '0;
        normal_ch.nrm_z         = '0;
        normal_ch.normal_finite = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = '0;
        cfg_ch.data             = '0;
        normals_sent            = 0;
        burst_left              = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed normals under the reset register values.
        send_normal(32767, 0, 0, 1'b1);
        send_normal(-32768, 0, 0, 1'b1);
        send_normal(0, 32767, 0, 1'b1);
        send_normal(0, -32768, 0, 1'b1);
        send_normal(0, 0, 32767, 1'b1);
        send_normal(0, 0, -32768, 1'b1);
        send_normal(0, 0, 0, 1'b1);
        send_normal(0, 0, 0, 1'b0);
        send_normal(12345, -222, 777, 1'b0);
        send_normal(32767, 32767, 32767, 1'b1);
        send_normal(-32768, -32768, -32768, 1'b1);
        send_normal(32767, -32768, 32767, 1'b1);
        send_normal(16384, 0, 0, 1'b1);
        send_normal(1, 0, 0, 1'b1);
        // With an odd ratio offset, equal unit components land exactly on a half.
        send_normal(1, 1, 0, 1'b1);
        send_normal(1, 1, 1, 1'b1);
        send_normal(-1, 1, -1, 1'b1);
        send_normal(1, -32768, 0, 1'b1);
        send_normal(11585, 11585, 0, 1'b1);
        send_normal(-32768, 32767, -1, 1'b1);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            normal_ch.valid <= 1'b0;
            drain_results();
            case (phase)
                0:
                begin
                    ratio = 0;
                    eps   = 0;
                end
                1:
                begin
                    ratio = 1073741;
                    eps   = 32'h001F_FFFF;
                end
                2:
                begin
                    ratio = 1073742;
                    eps   = 1073742;
                end
                3:
                begin
                    ratio = 1 << 30;
                    eps   = $urandom_range(0, 1073742);
                end
                4:
                begin
                    ratio = 32'h7FFF_FFFF;
                    eps   = 32'h001F_FFFF;
                end
                5:
                begin
                    ratio = $urandom;
                    eps   = $urandom;
                end
                6:
                begin
                    ratio = $urandom_range(1073742, 1 << 30);
                    eps   = $urandom_range(0, 1073742);
                end
                default:
                begin
                    ratio = $urandom_range(1 << 30, 32'h7FFF_FFFF);
                    eps   = 0;
                end
            endcase
            if ($urandom_range(0, 1))
            begin
                write_register(REG_NORMAL_RATIO, ratio);
                write_register(REG_DIAG_EPSILON, eps);
            end
            else
            begin
                write_register(REG_DIAG_EPSILON, eps);
                write_register(REG_NORMAL_RATIO, ratio);
            end
            // Writes to unused indexes must leave both registers alone.
            write_register(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1,
                                                     REG_DIAG_EPSILON + 1)), $urandom);

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_random_normal();
        end

        normal_ch.valid <= 1'b0;
        drain_results();
        repeat (PIPE_LATENCY + 3) @(posedge clk);

        $display("Run covered %0d normals over %0d register settings, from a ratio below its floor",
                 normals_sent, NUM_PHASES + 1);
        $display("to saturating ones, with zero, non-finite and axis normals; %0d items compared.",
                 compared);
        if (pending != 0)
            $display("%0t: %0d covariance items never arrived", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("%0t: timed out with %0d covariance items outstanding", $time, pending);
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/ntpc_pkg.sv
hw/rtl/ntpc_in_if.sv
hw/rtl/ntpc_out_if.sv
hw/rtl/ntpc_cfg_if.sv
hw/rtl/ntpc_div_pipe.sv
hw/rtl/normal_to_plane_covariance_unit.sv
test/plane_cov_checker.sv
test/testbench.sv
